[hdl/sixel_rle_encoder_assert.svh]
// Assertion helpers used by the request queue.
`ifndef SIXEL_RLE_ENCODER_ASSERT_SVH
`define SIXEL_RLE_ENCODER_ASSERT_SVH

// Same-cycle implication, quiet while reset is held.
`define SXL_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet while reset is held.
`define SXL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/sxl_pkg.sv]
`default_nettype none
package sxl_pkg;

    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int MAX_RUN_DEF       = 255;
    localparam int QUEUE_DEPTH       = 4;
    localparam int QUEUE_PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int START_LEN         = 10;

    localparam logic [2:0] REQ_PIXEL = 3'd0;
    localparam logic [2:0] REQ_LF    = 3'd1;
    localparam logic [2:0] REQ_START = 3'd2;
    localparam logic [2:0] REQ_END   = 3'd3;
    localparam logic [2:0] REQ_LOAD  = 3'd4;

    localparam logic [1:0] CFG_COLOR_COUNT = 2'd0;
    localparam logic [1:0] CFG_USE_8BIT    = 2'd1;
    localparam logic [1:0] CFG_PRINT_BG    = 2'd2;
    localparam logic [1:0] CFG_BG_COLOR    = 2'd3;

    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_TWO    = 8'h32;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DASH   = 8'h2d;
    localparam logic [7:0] CH_ESC    = 8'h1b;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_BSL    = 8'h5c;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_DCS8   = 8'h90;
    localparam logic [7:0] CH_ST8    = 8'h9c;
    localparam logic [6:0] SIXEL_BASE = 7'h3f;
    localparam logic [5:0] ROW_FIRST  = 6'h01;
    localparam logic [5:0] ROW_LAST   = 6'h20;

    typedef struct packed {
        logic [8:0] color_count;
        logic       use_8bit;
        logic       print_bg;
        logic [7:0] bg_color;
    } t_cfg;

    typedef enum logic [1:0] {
        K_RUN,
        K_START,
        K_END
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic        has_run;
        logic        lf;
        logic        dash;
        logic        cmode;
        logic        def;
        logic [7:0]  color;
        logic [7:0]  len;
        logic [6:0]  ch;
        logic [20:0] rgb;
    } t_cmd;

    typedef enum logic [4:0] {
        PH_IDLE,
        PH_D_HASH, PH_D_COL, PH_D_S1, PH_D_TWO, PH_D_S2,
        PH_D_R, PH_D_S3, PH_D_G, PH_D_S4, PH_D_B,
        PH_C_HASH, PH_C_COL,
        PH_R_BANG, PH_R_LEN, PH_R_CH2, PH_R_CH,
        PH_L_DOLLAR, PH_L_DASH,
        PH_S_LEAD, PH_S_P, PH_S_TXT,
        PH_E_DASH, PH_E_ST, PH_E_BSL
    } t_phase;

    function automatic logic [11:0] to_bcd(input logic [7:0] v);
        logic [19:0] s;
        s = {12'd0, v};
        for (int i = 0; i < 8; i++) begin
            if (s[11:8] >= 4'd5)  s[11:8]  = s[11:8] + 4'd3;
            if (s[15:12] >= 4'd5) s[15:12] = s[15:12] + 4'd3;
            if (s[19:16] >= 4'd5) s[19:16] = s[19:16] + 4'd3;
            s = s << 1;
        end
        return s[19:8];
    endfunction

    // Digit count minus one.
    function automatic logic [1:0] digits_m1(input logic [7:0] v);
        if (v >= 8'd100)
            return 2'd2;
        else if (v >= 8'd10)
            return 2'd1;
        return 2'd0;
    endfunction

    // After the introducer: 0;0;8 q and raster attributes "1;1
    function automatic logic [7:0] start_text(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h30;
            4'd1:    c = 8'h3b;
            4'd2:    c = 8'h30;
            4'd3:    c = 8'h3b;
            4'd4:    c = 8'h38;
            4'd5:    c = 8'h71;
            4'd6:    c = 8'h22;
            4'd7:    c = 8'h31;
            4'd8:    c = 8'h3b;
            default: c = 8'h31;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

[hdl/sxl_ram.sv]
`default_nettype none
module sxl_ram #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[hdl/sxl_front.sv]
`default_nettype none
module sxl_front #(
    parameter int PALETTE_DEPTH = sxl_pkg::PALETTE_DEPTH_DEF,
    parameter int MAX_RUN       = sxl_pkg::MAX_RUN_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire sxl_pkg::t_cfg                     i_cfg,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic [2:0]                        i_req_type,
    input  wire logic [7:0]                        i_color_index,
    input  wire logic [6:0]                        i_red_percent,
    input  wire logic [6:0]                        i_green_percent,
    input  wire logic [6:0]                        i_blue_percent,
    input  wire logic [sxl_pkg::QUEUE_CNT_W-1:0]   i_q_count,
    output logic                                   o_push,
    output sxl_pkg::t_cmd                          o_cmd
);

    localparam int AW = $clog2(PALETTE_DEPTH);
    localparam int CW = sxl_pkg::QUEUE_CNT_W + 1;

    logic [AW-1:0] w_mod [256];

    genvar g;
    for (g = 0; g < 256; g++) begin : g_mod
        assign w_mod[g] = AW'(g % PALETTE_DEPTH);
    end

    logic [7:0]               r_color, n_color;
    logic [7:0]               r_len, n_len;
    logic [5:0]               r_row, n_row;
    logic                     r_clr_busy;
    logic [AW-1:0]            r_clr_addr;
    logic                     r_s1_valid;
    sxl_pkg::t_cmd            r_s1, n_cmd;
    logic                     n_cmd_valid, n_set_sent;
    logic                     w_acc, w_cmode, w_load;
    logic [AW-1:0]            w_slot;
    logic [6:0]               w_ch;
    logic [20:0]              w_rgb;
    logic                     w_sent_we, w_sent_rd;
    logic [AW-1:0]            w_sent_addr;

    // hold the input off while sent marks clear after reset or the queue is full
    assign o_stall = r_clr_busy ||
                     ((CW'(i_q_count) + CW'(r_s1_valid)) >= CW'(sxl_pkg::QUEUE_DEPTH));
    assign w_acc   = i_valid && !o_stall;
    assign w_cmode = i_cfg.color_count > 9'd2;
    assign w_slot  = w_mod[r_color];
    assign w_load  = w_acc && (i_req_type == sxl_pkg::REQ_LOAD);

    always_comb begin
        if (w_cmode) begin
            w_ch = (!i_cfg.print_bg && r_color == i_cfg.bg_color) ? sxl_pkg::SIXEL_BASE
                 : sxl_pkg::SIXEL_BASE + {1'b0, r_row};
        end else begin
            w_ch = (r_color == 8'd0) ? sxl_pkg::SIXEL_BASE
                 : sxl_pkg::SIXEL_BASE + {1'b0, r_row};
        end
    end

    always_comb begin
        n_color     = r_color;
        n_len       = r_len;
        n_row       = r_row;
        n_cmd_valid = 1'b0;
        n_set_sent  = 1'b0;
        n_cmd.kind    = sxl_pkg::K_RUN;
        n_cmd.has_run = 1'b1;
        n_cmd.lf      = 1'b0;
        n_cmd.dash    = 1'b0;
        n_cmd.cmode   = w_cmode;
        n_cmd.def     = w_cmode;
        n_cmd.color   = r_color;
        n_cmd.len     = r_len;
        n_cmd.ch      = w_ch;
        n_cmd.rgb     = '0;
        unique case (i_req_type)
            sxl_pkg::REQ_PIXEL: begin
                if (r_len == 8'd0) begin
                    n_color = i_color_index;
                    n_len   = 8'd1;
                end else if (r_len < 8'(MAX_RUN) && r_color == i_color_index) begin
                    n_len = r_len + 8'd1;
                end else begin
                    // flush the pending run and open a new one
                    n_cmd_valid = 1'b1;
                    n_set_sent  = w_cmode;
                    n_color     = i_color_index;
                    n_len       = 8'd1;
                end
            end
            sxl_pkg::REQ_LF: begin
                n_cmd_valid   = 1'b1;
                n_cmd.has_run = r_len != 8'd0;
                n_cmd.lf      = 1'b1;
                n_cmd.dash    = r_row == sxl_pkg::ROW_LAST;
                n_set_sent    = w_cmode && r_len != 8'd0;
                n_row         = (r_row == sxl_pkg::ROW_LAST) ? sxl_pkg::ROW_FIRST
                              : {r_row[4:0], 1'b0};
                n_len         = 8'd0;
            end
            sxl_pkg::REQ_START: begin
                n_cmd_valid = 1'b1;
                n_cmd.kind  = sxl_pkg::K_START;
            end
            sxl_pkg::REQ_END: begin
                n_cmd_valid = 1'b1;
                n_cmd.kind  = sxl_pkg::K_END;
                n_cmd.dash  = r_row != sxl_pkg::ROW_FIRST;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= 8'd0;
            r_row      <= sxl_pkg::ROW_FIRST;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_acc && n_cmd_valid;
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(PALETTE_DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (w_acc) begin
                r_len <= n_len;
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_color <= n_color;
            r_s1    <= n_cmd;
        end
    end

    // Read the palette entry in step with the flush so later loads cannot overtake it.
    sxl_ram #(
        .WIDTH(21),
        .DEPTH(PALETTE_DEPTH)
    ) u_palette (
        .i_clk  (i_clk),
        .i_we   (w_load),
        .i_waddr(w_mod[i_color_index]),
        .i_wdata({i_red_percent, i_green_percent, i_blue_percent}),
        .i_raddr(w_slot),
        .o_rdata(w_rgb)
    );

    // the read at the flush edge sees the mark before this flush sets it
    assign w_sent_we   = r_clr_busy || (w_acc && n_set_sent);
    assign w_sent_addr = r_clr_busy ? r_clr_addr : w_slot;

    sxl_ram #(
        .WIDTH(1),
        .DEPTH(PALETTE_DEPTH)
    ) u_sent (
        .i_clk  (i_clk),
        .i_we   (w_sent_we),
        .i_waddr(w_sent_addr),
        .i_wdata(!r_clr_busy),
        .i_raddr(w_slot),
        .o_rdata(w_sent_rd)
    );

    always_comb begin
        o_cmd     = r_s1;
        o_cmd.rgb = w_rgb;
        o_cmd.def = r_s1.def && !w_sent_rd;
    end
    assign o_push = r_s1_valid;

endmodule
`default_nettype wire

[hdl/sxl_fifo.sv]
`default_nettype none
`include "sixel_rle_encoder_assert.svh"
module sxl_fifo (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_push,
    input  wire sxl_pkg::t_cmd                   i_cmd,
    input  wire logic                            i_pop,
    output sxl_pkg::t_cmd                        o_head,
    output logic                                 o_empty,
    output logic [sxl_pkg::QUEUE_CNT_W-1:0]      o_count
);

    localparam int PW = sxl_pkg::QUEUE_PTR_W;
    localparam int CW = sxl_pkg::QUEUE_CNT_W;

    sxl_pkg::t_cmd r_mem [sxl_pkg::QUEUE_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    assign o_head  = r_mem[r_rp];
    assign o_empty = r_count == '0;
    assign o_count = r_count;

    `SXL_ASSERT_IMPLY(a_no_overflow, i_clk, i_rst_n, i_push && !i_pop, r_count < CW'(sxl_pkg::QUEUE_DEPTH), "request queue overflow")
    `SXL_ASSERT_IMPLY(a_no_underflow, i_clk, i_rst_n, i_pop, r_count != '0, "pop from empty request queue")
    `SXL_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + CW'(1), "queue count lost a push")

endmodule
`default_nettype wire

[hdl/sxl_back.sv]
`default_nettype none
module sxl_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire sxl_pkg::t_cfg i_cfg,
    input  wire sxl_pkg::t_cmd i_head,
    input  wire logic          i_empty,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic [7:0]         o_out_byte,
    output logic               o_last
);

    sxl_pkg::t_phase r_phase, w_phase, w_first, w_next, w_run_start, w_flush_start;
    logic [3:0]  r_cnt;
    logic        r_ovalid, r_olast;
    logic [7:0]  r_obyte;
    logic        w_take, w_emit, w_end;
    logic [7:0]  w_byte, w_num, w_ch;
    logic [11:0] w_bcd;
    logic [1:0]  w_ndm1, w_pos;
    logic [3:0]  w_dig;
    logic        w_num_end;

    assign w_ch = {1'b0, i_head.ch};

    always_comb begin
        if (i_head.len > 8'd2)
            w_run_start = sxl_pkg::PH_R_BANG;
        else if (i_head.len == 8'd2)
            w_run_start = sxl_pkg::PH_R_CH2;
        else
            w_run_start = sxl_pkg::PH_R_CH;
        if (i_head.cmode)
            w_flush_start = i_head.def ? sxl_pkg::PH_D_HASH : sxl_pkg::PH_C_HASH;
        else
            w_flush_start = w_run_start;
        unique case (i_head.kind)
            sxl_pkg::K_RUN:   w_first = i_head.has_run ? w_flush_start : sxl_pkg::PH_L_DOLLAR;
            sxl_pkg::K_START: w_first = sxl_pkg::PH_S_LEAD;
            sxl_pkg::K_END:   w_first = i_head.dash ? sxl_pkg::PH_E_DASH : sxl_pkg::PH_E_ST;
            default:          w_first = sxl_pkg::PH_IDLE;
        endcase
    end

    assign w_phase = (r_phase == sxl_pkg::PH_IDLE) ? w_first : r_phase;

    always_comb begin
        case (w_phase)
            sxl_pkg::PH_D_R: w_num = {1'b0, i_head.rgb[20:14]};
            sxl_pkg::PH_D_G: w_num = {1'b0, i_head.rgb[13:7]};
            sxl_pkg::PH_D_B: w_num = {1'b0, i_head.rgb[6:0]};
            sxl_pkg::PH_R_LEN: w_num = i_head.len;
            default:         w_num = i_head.color;
        endcase
    end

    assign w_bcd     = sxl_pkg::to_bcd(w_num);
    assign w_ndm1    = sxl_pkg::digits_m1(w_num);
    assign w_pos     = w_ndm1 - r_cnt[1:0];
    assign w_num_end = r_cnt[1:0] == w_ndm1;

    always_comb begin
        case (w_pos)
            2'd0:    w_dig = w_bcd[3:0];
            2'd1:    w_dig = w_bcd[7:4];
            default: w_dig = w_bcd[11:8];
        endcase
    end

    always_comb begin
        w_byte = 8'd0;
        w_end  = 1'b1;
        w_next = sxl_pkg::PH_IDLE;
        unique case (w_phase)
            sxl_pkg::PH_D_HASH: begin w_byte = sxl_pkg::CH_HASH; w_next = sxl_pkg::PH_D_COL; end
            sxl_pkg::PH_D_COL: begin
                w_byte = sxl_pkg::CH_ZERO + {4'd0, w_dig};
                w_end  = w_num_end;
                w_next = sxl_pkg::PH_D_S1;
            end
            sxl_pkg::PH_D_S1:  begin w_byte = sxl_pkg::CH_SEMI; w_next = sxl_pkg::PH_D_TWO; end
            sxl_pkg::PH_D_TWO: begin w_byte = sxl_pkg::CH_TWO;  w_next = sxl_pkg::PH_D_S2; end
            sxl_pkg::PH_D_S2:  begin w_byte = sxl_pkg::CH_SEMI; w_next = sxl_pkg::PH_D_R; end
            sxl_pkg::PH_D_R: begin
                w_byte = sxl_pkg::CH_ZERO + {4'd0, w_dig};
                w_end  = w_num_end;
                w_next = sxl_pkg::PH_D_S3;
            end
            sxl_pkg::PH_D_S3:  begin w_byte = sxl_pkg::CH_SEMI; w_next = sxl_pkg::PH_D_G; end
            sxl_pkg::PH_D_G: begin
                w_byte = sxl_pkg::CH_ZERO + {4'd0, w_dig};
                w_end  = w_num_end;
                w_next = sxl_pkg::PH_D_S4;
            end
            sxl_pkg::PH_D_S4:  begin w_byte = sxl_pkg::CH_SEMI; w_next = sxl_pkg::PH_D_B; end
            sxl_pkg::PH_D_B: begin
                w_byte = sxl_pkg::CH_ZERO + {4'd0, w_dig};
                w_end  = w_num_end;
                w_next = sxl_pkg::PH_C_HASH;
            end
            sxl_pkg::PH_C_HASH: begin w_byte = sxl_pkg::CH_HASH; w_next = sxl_pkg::PH_C_COL; end
            sxl_pkg::PH_C_COL: begin
                w_byte = sxl_pkg::CH_ZERO + {4'd0, w_dig};
                w_end  = w_num_end;
                w_next = w_run_start;
            end
            sxl_pkg::PH_R_BANG: begin w_byte = sxl_pkg::CH_BANG; w_next = sxl_pkg::PH_R_LEN; end
            sxl_pkg::PH_R_LEN: begin
                w_byte = sxl_pkg::CH_ZERO + {4'd0, w_dig};
                w_end  = w_num_end;
                w_next = sxl_pkg::PH_R_CH;
            end
            sxl_pkg::PH_R_CH2: begin w_byte = w_ch; w_next = sxl_pkg::PH_R_CH; end
            sxl_pkg::PH_R_CH: begin
                w_byte = w_ch;
                w_next = i_head.lf ? sxl_pkg::PH_L_DOLLAR : sxl_pkg::PH_IDLE;
            end
            sxl_pkg::PH_L_DOLLAR: begin
                w_byte = sxl_pkg::CH_DOLLAR;
                w_next = i_head.dash ? sxl_pkg::PH_L_DASH : sxl_pkg::PH_IDLE;
            end
            sxl_pkg::PH_L_DASH: w_byte = sxl_pkg::CH_DASH;
            sxl_pkg::PH_S_LEAD: begin
                w_byte = i_cfg.use_8bit ? sxl_pkg::CH_DCS8 : sxl_pkg::CH_ESC;
                w_next = i_cfg.use_8bit ? sxl_pkg::PH_S_TXT : sxl_pkg::PH_S_P;
            end
            sxl_pkg::PH_S_P: begin w_byte = sxl_pkg::CH_P; w_next = sxl_pkg::PH_S_TXT; end
            sxl_pkg::PH_S_TXT: begin
                w_byte = sxl_pkg::start_text(r_cnt);
                w_end  = r_cnt == 4'(sxl_pkg::START_LEN - 1);
            end
            sxl_pkg::PH_E_DASH: begin w_byte = sxl_pkg::CH_DASH; w_next = sxl_pkg::PH_E_ST; end
            sxl_pkg::PH_E_ST: begin
                w_byte = i_cfg.use_8bit ? sxl_pkg::CH_ST8 : sxl_pkg::CH_ESC;
                w_next = i_cfg.use_8bit ? sxl_pkg::PH_IDLE : sxl_pkg::PH_E_BSL;
            end
            sxl_pkg::PH_E_BSL: w_byte = sxl_pkg::CH_BSL;
            default: begin
            end
        endcase
    end

    assign w_take = !r_ovalid || !i_stall;
    assign w_emit = !i_empty && w_take;
    assign o_pop  = w_emit && w_end && (w_next == sxl_pkg::PH_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= sxl_pkg::PH_IDLE;
            r_cnt    <= 4'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_ovalid <= 1'b1;
                if (w_end) begin
                    r_phase <= w_next;
                    r_cnt   <= 4'd0;
                end else begin
                    r_phase <= w_phase;
                    r_cnt   <= r_cnt + 4'd1;
                end
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_obyte <= w_byte;
            r_olast <= o_pop;
        end
    end

    assign o_valid    = r_ovalid;
    assign o_out_byte = r_obyte;
    assign o_last     = r_olast;

endmodule
`default_nettype wire

[hdl/sixel_rle_encoder.sv]
// Sixel run-length encoder.
// Input channel (i_valid / o_stall) takes one request per cycle: pixel, line feed,
// start, end or palette load. A request is taken when i_valid is high and o_stall low.
// Output channel (o_valid / i_stall) gives one stream byte per cycle while i_stall
// is low; o_last marks the final byte caused by a request. Pixels that extend a
// run, and palette loads, give no bytes.
// Requests are classified in the front end and queued (four deep) for the byte
// sequencer, so the input keeps taking one request a cycle while bytes drain and
// the queue has room. From an empty queue, a request goes through the front-end
// command register and a queue entry before its first byte is registered.
// The sequencer emits one byte per cycle while i_stall is low; a flush produces up
// to 29 bytes, so sustained throughput is set by bytes produced.
// The configuration port (i_cfg_valid / o_cfg_ready, always ready) writes one
// register per cycle; write it only while the encoder is idle.
// Synchronous reset clears the run and the row position; after reset o_stall stays
// high while all PALETTE_DEPTH palette sent marks are cleared.
// Palette colours are undefined until loaded.
// While i_stall is high the output byte holds; the queue fills and o_stall rises.
`default_nettype none
module sixel_rle_encoder #(
    parameter int PALETTE_DEPTH = sxl_pkg::PALETTE_DEPTH_DEF,
    parameter int MAX_RUN       = sxl_pkg::MAX_RUN_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [2:0] i_req_type,
    input  wire logic [7:0] i_color_index,
    input  wire logic [6:0] i_red_percent,
    input  wire logic [6:0] i_green_percent,
    input  wire logic [6:0] i_blue_percent,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_last,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [8:0] i_cfg_data
);

    sxl_pkg::t_cfg r_cfg;
    sxl_pkg::t_cmd w_push_cmd, w_head;
    logic          w_push, w_pop, w_empty;
    logic [sxl_pkg::QUEUE_CNT_W-1:0] w_count;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.color_count <= 9'd256;
            r_cfg.use_8bit    <= 1'b0;
            r_cfg.print_bg    <= 1'b0;
            r_cfg.bg_color    <= 8'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                sxl_pkg::CFG_COLOR_COUNT: r_cfg.color_count <= i_cfg_data;
                sxl_pkg::CFG_USE_8BIT:    r_cfg.use_8bit    <= i_cfg_data[0];
                sxl_pkg::CFG_PRINT_BG:    r_cfg.print_bg    <= i_cfg_data[0];
                sxl_pkg::CFG_BG_COLOR:    r_cfg.bg_color    <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    sxl_front #(
        .PALETTE_DEPTH(PALETTE_DEPTH),
        .MAX_RUN      (MAX_RUN)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_color_index  (i_color_index),
        .i_red_percent  (i_red_percent),
        .i_green_percent(i_green_percent),
        .i_blue_percent (i_blue_percent),
        .i_q_count      (w_count),
        .o_push         (w_push),
        .o_cmd          (w_push_cmd)
    );

    sxl_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_cmd  (w_push_cmd),
        .i_pop  (w_pop),
        .o_head (w_head),
        .o_empty(w_empty),
        .o_count(w_count)
    );

    sxl_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_head    (w_head),
        .i_empty   (w_empty),
        .o_pop     (w_pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_out_byte(o_out_byte),
        .o_last    (o_last)
    );

endmodule
`default_nettype wire
